### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the voxel face visibility RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define VFV_ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define VFV_ASSERT(name, prop, msg) \
   `VFV_ASSERT_CLK(name, clock, reset, prop, msg)

`endif

### rtl/vfv_pkg.sv
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types and constants of the voxel face visibility core.
// ----------------------------------------------------------------------------
package vfv_pkg;

   // Reachable coordinate span of the input fields
   localparam int POS_X_SPAN = 16;
   localparam int POS_Y_SPAN = 128;
   localparam int POS_Z_SPAN = 16;

   // Store address bus: wide enough for every reachable block
   localparam int STORE_AW = 15;

   localparam int COUNT_W = 21;
   localparam logic [COUNT_W-1:0] VERTS_UP   = COUNT_W'(36);
   localparam logic [COUNT_W-1:0] VERTS_DOWN = COUNT_W'((1 << COUNT_W) - 36);

   // Operation codes
   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_COLUMN = 2'd2;

   // Config register indexes
   localparam logic [1:0] CSR_AIR_CODE   = 2'd0;
   localparam logic [1:0] CSR_WATER_CODE = 2'd1;
   localparam logic [1:0] CSR_CHUNK_X    = 2'd2;
   localparam logic [1:0] CSR_CHUNK_Z    = 2'd3;

   localparam logic [7:0] AIR_RESET   = 8'd0;
   localparam logic [7:0] WATER_RESET = 8'd8;

   typedef struct packed {
      logic [7:0] block_type;
      logic [3:0] pos_z;
      logic [6:0] pos_y;
      logic [3:0] pos_x;
      logic [1:0] mode;
   } cmd_type;

   typedef struct packed {
      logic                we;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          wdata;
   } store_req_type;

   typedef struct packed {
      logic [5:0]         face_mask;
      logic               is_transparent;
      logic               is_solid;
      logic [3:0]         pos_x;
      logic [6:0]         pos_y;
      logic [3:0]         pos_z;
      logic [6:0]         ground_height;
      logic [COUNT_W-1:0] opaque_vertices;
      logic [COUNT_W-1:0] transparent_vertices;
   } seq_rsp_type;

   // Result word, first field in the high bits
   typedef struct packed {
      logic [COUNT_W-1:0] transparent_vertices;
      logic [COUNT_W-1:0] opaque_vertices;
      logic [6:0]         ground_height;
      logic [19:0]        world_z;
      logic [6:0]         world_y;
      logic [19:0]        world_x;
      logic               is_solid;
      logic               is_transparent;
      logic [5:0]         face_mask;
   } rsp_word_type;

endpackage

### rtl/voxel_face_visibility_core.sv
// ----------------------------------------------------------------------------
// voxel_face_visibility_core
// Voxel chunk store with block writes, vertex counts, exposed-face queries
// and column ground height.
// Write, face query and column scan results are registered; a column scan makes
// one store read per row. Out-of-chunk items go straight to the result.
// One word in flight: the next word is taken once the sequencer is idle again,
// which it becomes as the result is registered.
// Reset: synchronous; a clearing sweep of every store address holds req_tready
// low, config writes are taken during it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_face_visibility_core
   import vfv_pkg::*;
#(
   parameter int SIZE_X = 16,
   parameter int SIZE_Y = 128,
   parameter int SIZE_Z = 16
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,  // pos_x[3:0] pos_y[10:4] pos_z[14:11] block_type[22:15]
   input  logic [1:0]   req_tuser,  // mode[1:0]
   // Result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // face_mask[5:0] is_transparent[6] is_solid[7]
                                    // world_x[27:8] world_y[34:28] world_z[54:35]
                                    // ground_height[61:55] opaque_vertices[82:62]
                                    // transparent_vertices[103:83]
   // Config write port
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int XN = (SIZE_X < POS_X_SPAN) ? SIZE_X : POS_X_SPAN;
   localparam int YN = (SIZE_Y < POS_Y_SPAN) ? SIZE_Y : POS_Y_SPAN;
   localparam int ZN = (SIZE_Z < POS_Z_SPAN) ? SIZE_Z : POS_Z_SPAN;
   localparam int AW = $clog2(XN) + $clog2(YN) + $clog2(ZN);

   logic [7:0]    air_ff, air_in;
   logic [7:0]    water_ff, water_in;
   logic [15:0]   cpx_ff, cpx_in;
   logic [15:0]   cpz_ff, cpz_in;

   cmd_type       cmd;
   store_req_type store_req;
   logic [7:0]    rd_data;
   logic          clr_busy;
   logic          seq_idle;
   logic          seq_done;
   seq_rsp_type   seq_rsp;
   logic          out_free;
   logic          start;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_data_in;

   // Config registers
   always_comb begin
      air_in   = air_ff;
      water_in = water_ff;
      cpx_in   = cpx_ff;
      cpz_in   = cpz_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_AIR_CODE:   air_in   = csr_wdata[7:0];
            CSR_WATER_CODE: water_in = csr_wdata[7:0];
            CSR_CHUNK_X:    cpx_in   = csr_wdata;
            CSR_CHUNK_Z:    cpz_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         air_ff   <= AIR_RESET;
         water_ff <= WATER_RESET;
         cpx_ff   <= '0;
         cpz_ff   <= '0;
      end else begin
         air_ff   <= air_in;
         water_ff <= water_in;
         cpx_ff   <= cpx_in;
         cpz_ff   <= cpz_in;
      end
   end

   // Request unpack and handshake
   always_comb begin
      cmd.mode       = req_tuser;
      cmd.pos_x      = req_tdata[3:0];
      cmd.pos_y      = req_tdata[10:4];
      cmd.pos_z      = req_tdata[14:11];
      cmd.block_type = req_tdata[22:15];
   end

   assign req_tready = seq_idle && !clr_busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   vfv_store #(
      .AW (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (rd_data),
      .busy    (clr_busy)
   );

   vfv_seq #(
      .SIZE_X (SIZE_X),
      .SIZE_Y (SIZE_Y),
      .SIZE_Z (SIZE_Z)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (cmd),
      .air_code   (air_ff),
      .water_code (water_ff),
      .rd_data    (rd_data),
      .out_free   (out_free),
      .store_req  (store_req),
      .idle       (seq_idle),
      .done       (seq_done),
      .result     (seq_rsp)
   );

   // Result word; world coordinate is chunk*16 + pos, low nibble is pos
   always_comb begin
      rsp_data_in                      = rsp_data_ff;
      rsp_valid_in                     = rsp_valid_ff && !rsp_tready;
      if (seq_done) begin
         rsp_valid_in                     = 1'b1;
         rsp_data_in.face_mask            = seq_rsp.face_mask;
         rsp_data_in.is_transparent       = seq_rsp.is_transparent;
         rsp_data_in.is_solid             = seq_rsp.is_solid;
         rsp_data_in.world_x              = {cpx_ff, seq_rsp.pos_x};
         rsp_data_in.world_y              = seq_rsp.pos_y;
         rsp_data_in.world_z              = {cpz_ff, seq_rsp.pos_z};
         rsp_data_in.ground_height        = seq_rsp.ground_height;
         rsp_data_in.opaque_vertices      = seq_rsp.opaque_vertices;
         rsp_data_in.transparent_vertices = seq_rsp.transparent_vertices;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `VFV_ASSERT(a_clear_holds_req, clr_busy |-> !req_tready, "request taken during clear sweep")
   `VFV_ASSERT(a_busy_after_accept, start |=> !req_tready, "second word taken while busy")
   `VFV_ASSERT(a_mask_needs_solid, rsp_valid_ff && !rsp_data_ff.is_solid |-> rsp_data_ff.face_mask == 6'd0, "face mask on non-solid block")
   `VFV_ASSERT(a_water_is_solid, rsp_valid_ff && rsp_data_ff.is_transparent |-> rsp_data_ff.is_solid, "transparent block not solid")

endmodule

### rtl/vfv_store.sv
// ----------------------------------------------------------------------------
// vfv_store
// Block-type memory, one write and one registered read per cycle, with a
// clearing sweep after reset whose writes win over request writes.
// ----------------------------------------------------------------------------
module vfv_store
   import vfv_pkg::*;
#(
   parameter int AW = 15
) (
   input  logic          clock,
   input  logic          reset,
   input  store_req_type req,
   output logic [7:0]    rd_data,
   output logic          busy
);

   localparam int DEPTH = 1 << AW;

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          busy_ff, busy_in;
   logic [7:0]    rd_data_ff;

   // Clear sweep control
   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in     = busy_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == {AW{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         busy_ff     <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         busy_ff     <= busy_in;
      end
   end

   // Memory array: sweep write wins, read data registered
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= 8'd0;
      end else if (req.we) begin
         mem[req.addr[AW-1:0]] <= req.wdata;
      end
      rd_data_ff <= mem[req.addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

### rtl/vfv_seq.sv
// ----------------------------------------------------------------------------
// vfv_seq
// Sequencer around one shared block classifier and one count adder: walks the
// store for writes, six-neighbor face queries and column height scans.
// ----------------------------------------------------------------------------
module vfv_seq
   import vfv_pkg::*;
#(
   parameter int SIZE_X = 16,
   parameter int SIZE_Y = 128,
   parameter int SIZE_Z = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  cmd_type       cmd,
   input  logic [7:0]    air_code,
   input  logic [7:0]    water_code,
   input  logic [7:0]    rd_data,
   input  logic          out_free,
   output store_req_type store_req,
   output logic          idle,
   output logic          done,
   output seq_rsp_type   result
);

   // Reachable extent of each axis
   localparam int XN = (SIZE_X < POS_X_SPAN) ? SIZE_X : POS_X_SPAN;
   localparam int YN = (SIZE_Y < POS_Y_SPAN) ? SIZE_Y : POS_Y_SPAN;
   localparam int ZN = (SIZE_Z < POS_Z_SPAN) ? SIZE_Z : POS_Z_SPAN;
   localparam int XW = $clog2(XN);
   localparam int YW = $clog2(YN);
   localparam int ZW = $clog2(ZN);

   localparam logic [6:0] XLAST = 7'(SIZE_X - 1);
   localparam logic [6:0] ZLAST = 7'(SIZE_Z - 1);
   localparam logic [7:0] YLAST = 8'(SIZE_Y - 1);
   localparam logic [3:0] XTOP  = 4'(XN - 1);
   localparam logic [3:0] ZTOP  = 4'(ZN - 1);
   localparam logic [6:0] YTOP  = 7'(YN - 1);
   localparam logic [4:0] XLIM  = 5'(XN);
   localparam logic [4:0] ZLIM  = 5'(ZN);
   localparam logic [7:0] YLIM  = 8'(YN);

   // Query steps; neighbor step n sets mask bit n-1
   localparam logic [2:0] ST_CENTER = 3'd0;
   localparam logic [2:0] ST_ZP     = 3'd1;
   localparam logic [2:0] ST_XP     = 3'd2;
   localparam logic [2:0] ST_ZM     = 3'd3;
   localparam logic [2:0] ST_XM     = 3'd4;
   localparam logic [2:0] ST_YP     = 3'd5;
   localparam logic [2:0] ST_YM     = 3'd6;
   localparam logic [2:0] ST_LAST   = 3'd7;

   typedef enum logic [2:0] {
      S_IDLE, S_QRY, S_SCAN, S_WR_RD, S_WR_OLD, S_WR_NEW, S_DONE
   } state_type;

   function automatic logic [STORE_AW-1:0] pack_addr(input logic [3:0] x,
                                                     input logic [6:0] y,
                                                     input logic [3:0] z);
      return STORE_AW'({y[YW-1:0], z[ZW-1:0], x[XW-1:0]});
   endfunction

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [2:0]         step_ff, step_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [2:0]         chk_idx_ff, chk_idx_in;
   logic               chk_edge_ff, chk_edge_in;
   logic               chk_zero_ff, chk_zero_in;
   logic [6:0]         chk_y_ff, chk_y_in;
   logic [6:0]         yscan_ff, yscan_in;
   logic [5:0]         mask_ff, mask_in;
   logic               solid_ff, solid_in;
   logic               transp_ff, transp_in;
   logic [6:0]         ground_ff, ground_in;
   logic [COUNT_W-1:0] opq_ff, opq_in;
   logic [COUNT_W-1:0] trn_ff, trn_in;

   logic [3:0]         nb_x, nb_z;
   logic [6:0]         nb_y;
   logic               nb_edge, nb_zero;
   logic [7:0]         cmp_val;
   logic               cmp_air, cmp_water;
   logic [COUNT_W-1:0] cnt_sum;
   logic               in_chunk, in_column;

   // Neighbor coordinate and edge flags for the current query step
   always_comb begin
      nb_x    = cmd_ff.pos_x;
      nb_y    = cmd_ff.pos_y;
      nb_z    = cmd_ff.pos_z;
      nb_edge = 1'b0;
      nb_zero = 1'b0;
      case (step_ff)
         ST_ZP: begin
            nb_edge = ({3'b000, cmd_ff.pos_z} == ZLAST);
            nb_zero = !nb_edge && (cmd_ff.pos_z == ZTOP);
            nb_z    = cmd_ff.pos_z + 4'd1;
         end
         ST_XP: begin
            nb_edge = ({3'b000, cmd_ff.pos_x} == XLAST);
            nb_zero = !nb_edge && (cmd_ff.pos_x == XTOP);
            nb_x    = cmd_ff.pos_x + 4'd1;
         end
         ST_ZM: begin
            nb_edge = (cmd_ff.pos_z == 4'd0);
            nb_z    = cmd_ff.pos_z - 4'd1;
         end
         ST_XM: begin
            nb_edge = (cmd_ff.pos_x == 4'd0);
            nb_x    = cmd_ff.pos_x - 4'd1;
         end
         ST_YP: begin
            nb_edge = ({1'b0, cmd_ff.pos_y} == YLAST);
            nb_zero = !nb_edge && (cmd_ff.pos_y == YTOP);
            nb_y    = cmd_ff.pos_y + 7'd1;
         end
         ST_YM: begin
            nb_edge = (cmd_ff.pos_y == 7'd0);
            nb_y    = cmd_ff.pos_y - 7'd1;
         end
         default: ;
      endcase
   end

   // Shared classifier: store word, forced zero beyond the store, or new type
   always_comb begin
      if (state_ff == S_WR_NEW) begin
         cmp_val = cmd_ff.block_type;
      end else if (chk_zero_ff) begin
         cmp_val = 8'd0;
      end else begin
         cmp_val = rd_data;
      end
      cmp_air   = (cmp_val == air_code);
      cmp_water = (cmp_val == water_code);
   end

   // Shared count adder, up for the new block, down for the old one
   assign cnt_sum = (cmp_water ? trn_ff : opq_ff)
                  + ((state_ff == S_WR_NEW) ? VERTS_UP : VERTS_DOWN);

   assign in_column = ({1'b0, cmd.pos_x} < XLIM) && ({1'b0, cmd.pos_z} < ZLIM);
   assign in_chunk  = in_column && ({1'b0, cmd.pos_y} < YLIM);

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      step_in     = step_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      chk_edge_in = 1'b0;
      chk_zero_in = 1'b0;
      chk_y_in    = chk_y_ff;
      yscan_in    = yscan_ff;
      mask_in     = mask_ff;
      solid_in    = solid_ff;
      transp_in   = transp_ff;
      ground_in   = ground_ff;
      opq_in      = opq_ff;
      trn_in      = trn_ff;

      store_req.we    = 1'b0;
      store_req.addr  = pack_addr(cmd_ff.pos_x, cmd_ff.pos_y, cmd_ff.pos_z);
      store_req.wdata = cmd_ff.block_type;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = cmd;
               step_in   = ST_CENTER;
               yscan_in  = YTOP;
               mask_in   = '0;
               solid_in  = 1'b0;
               transp_in = 1'b0;
               ground_in = '0;
               unique case (cmd.mode)
                  MODE_WRITE:  state_in = in_chunk ? S_WR_RD : S_DONE;
                  MODE_QUERY:  state_in = in_chunk ? S_QRY : S_DONE;
                  MODE_COLUMN: state_in = in_column ? S_SCAN : S_DONE;
                  default:     state_in = S_DONE;
               endcase
            end
         end

         // Issue one read per step, judge the word read a step earlier
         S_QRY: begin
            store_req.addr = pack_addr(nb_x, nb_y, nb_z);
            chk_vld_in     = (step_ff != ST_LAST);
            chk_idx_in     = step_ff;
            chk_edge_in    = nb_edge;
            chk_zero_in    = nb_zero;
            if (chk_vld_ff) begin
               if (chk_idx_ff == ST_CENTER) begin
                  solid_in  = !cmp_air;
                  transp_in = cmp_water && !cmp_air;
               end else begin
                  mask_in[chk_idx_ff - 3'd1] = chk_edge_ff || cmp_air;
               end
            end
            step_in = step_ff + 3'd1;
            if (step_ff == ST_LAST) begin
               state_in = S_DONE;
            end
         end

         // Walk the column downward, one read per cycle
         S_SCAN: begin
            store_req.addr = pack_addr(cmd_ff.pos_x, yscan_ff, cmd_ff.pos_z);
            if (chk_vld_ff && !cmp_air) begin
               ground_in = chk_y_ff;
               state_in  = S_DONE;
            end else if (chk_vld_ff && (chk_y_ff == 7'd1)) begin
               state_in = S_DONE;
            end else begin
               chk_vld_in = 1'b1;
               chk_y_in   = yscan_ff;
               yscan_in   = yscan_ff - 7'd1;
            end
         end

         S_WR_RD: begin
            state_in = S_WR_OLD;
         end

         // Remove the old block's share
         S_WR_OLD: begin
            if (!cmp_air) begin
               if (cmp_water) trn_in = cnt_sum;
               else           opq_in = cnt_sum;
            end
            state_in = S_WR_NEW;
         end

         // Store the new block and add its share
         S_WR_NEW: begin
            store_req.we = 1'b1;
            if (!cmp_air) begin
               if (cmp_water) trn_in = cnt_sum;
               else           opq_in = cnt_sum;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         chk_vld_ff <= 1'b0;
         opq_ff     <= '0;
         trn_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         opq_ff     <= opq_in;
         trn_ff     <= trn_in;
      end
      cmd_ff      <= cmd_in;
      step_ff     <= step_in;
      chk_idx_ff  <= chk_idx_in;
      chk_edge_ff <= chk_edge_in;
      chk_zero_ff <= chk_zero_in;
      chk_y_ff    <= chk_y_in;
      yscan_ff    <= yscan_in;
      mask_ff     <= mask_in;
      solid_ff    <= solid_in;
      transp_ff   <= transp_in;
      ground_ff   <= ground_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign done = (state_ff == S_DONE) && out_free;

   // Air center hides every face
   always_comb begin
      result.face_mask            = solid_ff ? mask_ff : 6'd0;
      result.is_transparent       = transp_ff;
      result.is_solid             = solid_ff;
      result.pos_x                = cmd_ff.pos_x;
      result.pos_y                = cmd_ff.pos_y;
      result.pos_z                = cmd_ff.pos_z;
      result.ground_height        = ground_ff;
      result.opaque_vertices      = opq_ff;
      result.transparent_vertices = trn_ff;
   end

endmodule
